FILE: rtl/palette_color_cycling_lookup_core_macros.svh
// Assertion macros used by the port-level checker.
`ifndef PALETTE_COLOR_CYCLING_LOOKUP_CORE_MACROS_SVH
`define PALETTE_COLOR_CYCLING_LOOKUP_CORE_MACROS_SVH

// Implication checked outside reset.
`define PCCL_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pccl assertion failed");

// Implication checked at every edge, reset included.
`define PCCL_ASSERT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error("pccl assertion failed");

`endif

FILE: rtl/pccl_pkg.sv
// Types and constants of the color-cycling palette lookup core.
package pccl_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_RANGES      = 16;
   localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam int SLOT_W          = $clog2(MAX_RANGES);
   localparam int QUO_W           = 16;
   localparam int DIV_STAGES      = QUO_W / 2;
   // start sample to strobe sample, in clock edges
   localparam int LOOKUP_LATENCY  = DIV_STAGES + 7;

   localparam logic [31:0] RB_MASK = 32'h00ff00ff;
   localparam logic [31:0] G_MASK  = 32'h0000ff00;
   localparam logic [8:0]  W_ONE   = 9'h100;

   typedef enum logic [1:0] {
      OP_PAL_WRITE   = 2'd0,
      OP_RANGE_WRITE = 2'd1,
      OP_LOOKUP      = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_BLEND_ENABLE = 1'b0,
      CSR_RANGE_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type       operation;
      logic [7:0]   slot_or_index;
      logic [23:0]  entry_rgb;
      logic [7:0]   range_first;
      logic [7:0]   range_last;
      logic [15:0]  range_speed;
      logic         range_backward;
      logic [31:0]  frame_position;
   } req_type;

   typedef struct packed {
      logic [7:0]   pixel_index;
      logic [23:0]  cycled_rgb;
   } rsp_type;

   typedef struct packed {
      logic [7:0]   first;
      logic [7:0]   last;
      logic [15:0]  speed;
      logic         backward;
   } range_type;

   typedef struct packed {
      logic         vld;
      op_type       op;
      logic [7:0]   idx;
      logic [23:0]  rgb;
      logic [31:0]  frame;
      logic         oor;
      logic         hit;
      logic [7:0]   first;
      logic [8:0]   n;
      logic [7:0]   k;
      logic         backward;
      logic [15:0]  speed;
      logic [31:0]  prod_a;
      logic [31:0]  prod_b;
      logic [QUO_W-1:0] quo;
      logic [8:0]   rem;
      logic [7:0]   w1;
      logic [7:0]   addr0;
      logic [7:0]   addr1;
   } pipe_type;

endpackage

FILE: rtl/palette_color_cycling_lookup_core.sv
// Color-cycling palette lookup core: fully pipelined, one item per clock.
//
// The core takes one item in every clock cycle (busy stays low) and gives the
// result of each lookup in the order taken, marked by rsp_strobe for one
// cycle. A lookup passes through the range match, the frame scaling multiply,
// an 8-stage remainder pipeline (two quotient bits per stage) and the
// registered two-port palette read, in that order. Palette and range writes
// pass down the same pipeline, so every lookup sees exactly the writes issued
// before it. Palette entries and range slots read before being written return
// arbitrary data. blend_enable and range_count may change only while no item
// is in flight.
module palette_color_cycling_lookup_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pccl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pccl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [4:0]        csr_wdata
);

   logic       blend_ff;
   logic [4:0] range_count_ff;

   logic              st1_vld_ff;
   pccl_pkg::req_type st1_ff;
   pccl_pkg::pipe_type st2_ff, st2_in;
   pccl_pkg::pipe_type st3_ff, st3_in;
   pccl_pkg::pipe_type dv_ff [pccl_pkg::DIV_STAGES+1];
   pccl_pkg::pipe_type dv_in [pccl_pkg::DIV_STAGES+1];
   pccl_pkg::pipe_type addr_ff, addr_in;
   pccl_pkg::pipe_type mem_ff;
   logic [23:0] rd0_ff, rd1_ff;

   pccl_pkg::range_type rng_ff [pccl_pkg::MAX_RANGES];
   logic [23:0] pal_mem [pccl_pkg::PALETTE_ENTRIES];

   logic              rsp_strobe_ff, rsp_strobe_in;
   pccl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff       <= 1'b0;
         range_count_ff <= 5'd0;
      end else if (csr_we) begin
         unique case (pccl_pkg::csr_index_type'(csr_index))
            pccl_pkg::CSR_BLEND_ENABLE: blend_ff       <= csr_wdata[0];
            pccl_pkg::CSR_RANGE_COUNT:  range_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_vld_ff <= 1'b0;
      end else begin
         st1_vld_ff <= start;
      end
      st1_ff <= req_data;
   end

   // range table writes, in order with lookups
   always_ff @(posedge clock) begin
      if (st1_vld_ff && st1_ff.operation == pccl_pkg::OP_RANGE_WRITE &&
          9'(st1_ff.slot_or_index) < 9'(pccl_pkg::MAX_RANGES)) begin
         rng_ff[st1_ff.slot_or_index[pccl_pkg::SLOT_W-1:0]] <=
            '{first: st1_ff.range_first, last: st1_ff.range_last,
              speed: st1_ff.range_speed, backward: st1_ff.range_backward};
      end
   end

   // range match: last active slot containing the index wins
   always_comb begin
      pccl_pkg::range_type sel;
      logic hit;
      sel = rng_ff[0];
      hit = 1'b0;
      for (int s = 0; s < pccl_pkg::MAX_RANGES; s++) begin
         if (s < int'(range_count_ff) &&
             rng_ff[s].last >= rng_ff[s].first &&
             9'(rng_ff[s].last) < 9'(pccl_pkg::PALETTE_ENTRIES) &&
             st1_ff.slot_or_index >= rng_ff[s].first &&
             st1_ff.slot_or_index <= rng_ff[s].last) begin
            hit = 1'b1;
            sel = rng_ff[s];
         end
      end
      st2_in          = '0;
      st2_in.vld      = st1_vld_ff;
      st2_in.op       = st1_ff.operation;
      st2_in.idx      = st1_ff.slot_or_index;
      st2_in.rgb      = st1_ff.entry_rgb;
      st2_in.frame    = st1_ff.frame_position;
      st2_in.oor      = 9'(st1_ff.slot_or_index) >= 9'(pccl_pkg::PALETTE_ENTRIES);
      st2_in.hit      = hit;
      st2_in.first    = sel.first;
      st2_in.n        = 9'(sel.last) - 9'(sel.first) + 9'd1;
      st2_in.k        = st1_ff.slot_or_index - sel.first;
      st2_in.backward = sel.backward;
      st2_in.speed    = sel.speed;
   end

   // frame scaling products
   always_comb begin
      st3_in        = st2_ff;
      st3_in.prod_a = 32'(32'(st2_ff.frame[31:16]) * 32'({st2_ff.speed, 2'b00}));
      st3_in.prod_b = 32'(32'(st2_ff.frame[15:0]) * 32'(st2_ff.speed)) >> 14;
   end

   // scaled frame, then remainder by range length, two bits per stage
   always_comb begin
      pccl_pkg::pipe_type tmp;
      logic [31:0] scaled;
      logic [9:0]  sh;
      scaled     = st3_ff.prod_a + st3_ff.prod_b;
      tmp        = st3_ff;
      tmp.quo    = scaled[31:16];
      tmp.w1     = scaled[15:8];
      tmp.rem    = 9'd0;
      dv_in[0]   = tmp;
      for (int j = 0; j < pccl_pkg::DIV_STAGES; j++) begin
         tmp = dv_ff[j];
         for (int b = 0; b < 2; b++) begin
            sh = {tmp.rem, tmp.quo[pccl_pkg::QUO_W-1]};
            if (sh >= {1'b0, tmp.n}) begin
               sh = sh - {1'b0, tmp.n};
            end
            tmp.rem = sh[8:0];
            tmp.quo = {tmp.quo[pccl_pkg::QUO_W-2:0], 1'b0};
         end
         dv_in[j+1] = tmp;
      end
   end

   // rotation and palette addresses
   always_comb begin
      pccl_pkg::pipe_type d;
      logic [8:0] off;
      logic [9:0] sum;
      logic [7:0] c0, c1;
      d   = dv_ff[pccl_pkg::DIV_STAGES];
      off = d.rem;
      if (!d.backward && off != 9'd0) begin
         off = d.n - off;
      end
      sum = {2'b00, d.k} + {1'b0, off};
      if (sum >= {1'b0, d.n}) begin
         sum = sum - {1'b0, d.n};
      end
      c0 = sum[7:0];
      c1 = (c0 == 8'd0) ? 8'(d.n - 9'd1) : c0 - 8'd1;
      addr_in = d;
      if (d.hit) begin
         addr_in.addr0 = d.first + c0;
         addr_in.addr1 = d.first + c1;
      end else begin
         addr_in.addr0 = d.idx;
         addr_in.addr1 = d.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff.vld  <= 1'b0;
         st3_ff.vld  <= 1'b0;
         addr_ff.vld <= 1'b0;
         mem_ff.vld  <= 1'b0;
         for (int j = 0; j <= pccl_pkg::DIV_STAGES; j++) begin
            dv_ff[j].vld <= 1'b0;
         end
      end else begin
         st2_ff  <= st2_in;
         st3_ff  <= st3_in;
         addr_ff <= addr_in;
         mem_ff  <= addr_ff;
         for (int j = 0; j <= pccl_pkg::DIV_STAGES; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // palette memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (addr_ff.vld && addr_ff.op == pccl_pkg::OP_PAL_WRITE && !addr_ff.oor) begin
         pal_mem[addr_ff.idx[pccl_pkg::PAL_ADDR_W-1:0]] <= addr_ff.rgb;
      end
      rd0_ff <= pal_mem[addr_ff.addr0[pccl_pkg::PAL_ADDR_W-1:0]];
      rd1_ff <= pal_mem[addr_ff.addr1[pccl_pkg::PAL_ADDR_W-1:0]];
   end

   // blend and drive the result beat
   always_comb begin
      logic [8:0]  w1, w0;
      logic [31:0] rb, g;
      w1 = {1'b0, mem_ff.w1};
      w0 = pccl_pkg::W_ONE - w1;
      rb = 32'(((32'(rd0_ff) & pccl_pkg::RB_MASK) * 32'(w0) +
                (32'(rd1_ff) & pccl_pkg::RB_MASK) * 32'(w1)) >> 8) & pccl_pkg::RB_MASK;
      g  = 32'(((32'(rd0_ff) & pccl_pkg::G_MASK) * 32'(w0) +
                (32'(rd1_ff) & pccl_pkg::G_MASK) * 32'(w1)) >> 8) & pccl_pkg::G_MASK;
      rsp_strobe_in           = mem_ff.vld && mem_ff.op == pccl_pkg::OP_LOOKUP;
      rsp_data_in.pixel_index = mem_ff.idx;
      if (mem_ff.oor) begin
         rsp_data_in.cycled_rgb = 24'd0;
      end else if (mem_ff.hit && blend_ff) begin
         rsp_data_in.cycled_rgb = 24'(rb | g);
      end else begin
         rsp_data_in.cycled_rgb = rd0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/pccl_checker.sv
// Port-level checker for the color-cycling palette lookup core, with its bind.
`include "palette_color_cycling_lookup_core_macros.svh"

module pccl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input pccl_pkg::req_type req_data,
   input logic              rsp_strobe,
   input pccl_pkg::rsp_type rsp_data
);

   `PCCL_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_strobe)
   `PCCL_ASSERT_IMPL(a_strobe_from_lookup, clock, reset, rsp_strobe, $past(start && !busy && req_data.operation == pccl_pkg::OP_LOOKUP, pccl_pkg::LOOKUP_LATENCY))
   `PCCL_ASSERT_IMPL(a_index_echo, clock, reset, rsp_strobe, rsp_data.pixel_index == $past(req_data.slot_or_index, pccl_pkg::LOOKUP_LATENCY))
   `PCCL_ASSERT_IMPL(a_never_busy, clock, reset, start, !busy)

endmodule

bind palette_color_cycling_lookup_core pccl_checker u_pccl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

FILE: tb/sv/tb_palette_color_cycling_lookup_core.sv
// Self-checking testbench for the color-cycling palette lookup core.
`timescale 1ns / 1ps

module tb_palette_color_cycling_lookup_core;
   import pccl_pkg::*;

   localparam int SETTLE_CYCLES = LOOKUP_LATENCY + 6;
   localparam int CYCLE_LIMIT   = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [0:0] csr_index = CSR_BLEND_ENABLE;
   logic [4:0] csr_wdata = '0;

   palette_color_cycling_lookup_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow state of the core
   bit [23:0] palette_shadow [PALETTE_ENTRIES];
   range_type range_shadow [MAX_RANGES];
   bit        blend_on;
   bit [4:0]  ranges_used;

   req_type   pending_beats [$];
   rsp_type   expected_colors [$];
   bit        no_gaps;
   int        gap_left;
   int        mismatches;
   int        colors_checked;
   int        beats_sent;
   int        cycle_count;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit [23:0] blend_rgb(bit [23:0] c0, bit [23:0] c1,
                                          bit [8:0] w0, bit [8:0] w1);
      bit [31:0] rb;
      bit [31:0] g;
      rb = ((({8'h0, c0} & RB_MASK) * w0 + ({8'h0, c1} & RB_MASK) * w1) >> 8) & RB_MASK;
      g  = ((({8'h0, c0} & G_MASK) * w0 + ({8'h0, c1} & G_MASK) * w1) >> 8) & G_MASK;
      return rb[23:0] | g[23:0];
   endfunction

   function automatic bit [23:0] cycled_color(bit [7:0] idx, bit [31:0] frame);
      bit [23:0]   color;
      int unsigned limit;
      int unsigned n, off, k, c0, c1;
      bit [31:0]   scaled;
      bit [31:0]   frac_prod;
      bit [8:0]    w1;
      range_type   r;
      color = palette_shadow[idx];
      limit = (ranges_used > MAX_RANGES) ? MAX_RANGES : ranges_used;
      for (int s = 0; s < limit; s++) begin
         r = range_shadow[s];
         if (r.last < r.first) continue;
         if (idx < r.first || idx > r.last) continue;
         n = r.last - r.first + 1;
         frac_prod = {16'h0, frame[15:0]} * {16'h0, r.speed};
         scaled = {16'h0, frame[31:16]} * {14'h0, r.speed, 2'b00} + (frac_prod >> 14);
         off = (scaled >> 16) % n;
         if (!r.backward) off = (n - off) % n;
         k  = idx - r.first;
         c0 = (k + off) % n;
         if (blend_on) begin
            w1 = {1'b0, scaled[15:8]};
            c1 = (c0 + n - 1) % n;
            color = blend_rgb(palette_shadow[r.first + c0], palette_shadow[r.first + c1],
                              W_ONE - w1, w1);
         end else begin
            color = palette_shadow[r.first + c0];
         end
      end
      return color;
   endfunction

   function automatic void absorb_beat(req_type r);
      rsp_type e;
      case (r.operation)
         OP_PAL_WRITE: palette_shadow[r.slot_or_index] = r.entry_rgb;
         OP_RANGE_WRITE: begin
            if (r.slot_or_index < MAX_RANGES)
               range_shadow[r.slot_or_index] = '{r.range_first, r.range_last,
                                                  r.range_speed, r.range_backward};
         end
         OP_LOOKUP: begin
            e.pixel_index = r.slot_or_index;
            e.cycled_rgb  = cycled_color(r.slot_or_index, r.frame_position);
            expected_colors.push_back(e);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_beat(op_type op, bit [7:0] idx, bit [23:0] rgb,
                                         bit [7:0] first, bit [7:0] last,
                                         bit [15:0] speed, bit back, bit [31:0] frame);
      req_type r;
      r.operation      = op;
      r.slot_or_index  = idx;
      r.entry_rgb      = rgb;
      r.range_first    = first;
      r.range_last     = last;
      r.range_speed    = speed;
      r.range_backward = back;
      r.frame_position = frame;
      return r;
   endfunction

   function automatic bit [15:0] pick_speed();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type     r;
      int unsigned pick;
      int unsigned span;
      r = make_beat(OP_LOOKUP, 8'($urandom), 24'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom), 1'($urandom), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         r.operation = OP_LOOKUP;
      end else if (pick < 83) begin
         r.operation = OP_PAL_WRITE;
      end else if (pick < 95) begin
         // well-formed range: mostly short spans, sometimes wide
         r.operation     = OP_RANGE_WRITE;
         r.slot_or_index = 8'($urandom_range(0, MAX_RANGES - 1));
         span = ($urandom_range(0, 3) == 0) ? 255 : 15;
         r.range_first = 8'($urandom_range(0, 255));
         r.range_last  = 8'($urandom_range(r.range_first,
                               (r.range_first + span > 255) ? 255 : r.range_first + span));
         r.range_speed = pick_speed();
      end else if (pick < 98) begin
         r.operation = OP_RANGE_WRITE;
         if ($urandom_range(0, 1)) begin
            r.slot_or_index = 8'($urandom_range(MAX_RANGES, 255));
         end else begin
            r.slot_or_index = 8'($urandom_range(0, MAX_RANGES - 1));
            r.range_first   = 8'($urandom_range(1, 255));
            r.range_last    = 8'($urandom_range(0, r.range_first - 1));
         end
      end else begin
         r.operation = OP_NONE;
      end
      return r;
   endfunction

   // driver: hold a beat until accepted, insert random gaps
   always @(posedge clock) begin
      bit drive;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            absorb_beat(req_data);
            beats_sent++;
         end
         drive = start && busy;
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               if (!no_gaps && $urandom_range(0, 11) == 0) begin
                  gap_left = $urandom_range(1, 17);
               end else begin
                  req_data <= pending_beats.pop_front();
                  drive = 1'b1;
               end
            end
         end
         start <= drive;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: index %0d rgb %06h",
                        rsp_data.pixel_index, rsp_data.cycled_rgb);
         end else begin
            e = expected_colors.pop_front();
            colors_checked++;
            if (rsp_data.pixel_index !== e.pixel_index ||
                rsp_data.cycled_rgb !== e.cycled_rgb) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected index %0d rgb %06h, got index %0d rgb %06h",
                           e.pixel_index, e.cycled_rgb,
                           rsp_data.pixel_index, rsp_data.cycled_rgb);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_palette_color_cycling_lookup_core: FAIL");
         $finish;
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (pending_beats.size() != 0 || start || gap_left != 0 ||
             expected_colors.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [4:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_BLEND_ENABLE) blend_on = value[0];
      else ranges_used = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_beats.push_back(random_beat());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // load every palette entry and range slot so no lookup reads stale state
      for (int i = 0; i < PALETTE_ENTRIES; i++)
         pending_beats.push_back(make_beat(OP_PAL_WRITE, 8'(i), 24'($urandom),
                                           8'($urandom), 8'($urandom), 16'($urandom),
                                           1'($urandom), $urandom));
      pending_beats[0].entry_rgb   = 24'h000000;
      pending_beats[255].entry_rgb = 24'hffffff;
      for (int s = 0; s < MAX_RANGES; s++)
         pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'(s), '0, 8'(s * 4),
                                           8'(s * 4 + 3), 16'(s * 1000), 1'(s), '0));
      // no ranges active yet: plain palette reads
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd0, '0, '0, '0, '0, 1'b0, 32'h0));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd255, '0, '0, '0, '0, 1'b0, 32'hffffffff));
      drain();

      write_csr(CSR_RANGE_COUNT, 5'd16);
      // whole-palette range at the fastest speed in both directions, then a still range
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd15, '0, 8'd0, 8'd255,
                                        16'hffff, 1'b0, '0));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd0, '0, '0, '0, '0, 1'b0, 32'hffffffff));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd255, '0, '0, '0, '0, 1'b0, 32'h00018000));
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd15, '0, 8'd0, 8'd255,
                                        16'hffff, 1'b1, '0));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd128, '0, '0, '0, '0, 1'b0, 32'h7fffffff));
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd14, '0, 8'd10, 8'd20,
                                        16'h0000, 1'b0, '0));
      // drop slot 15 with a malformed range, then hit the still range
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd15, '0, 8'd30, 8'd29,
                                        16'h1234, 1'b0, '0));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd12, '0, '0, '0, '0, 1'b0, 32'h00123456));
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd16, '0, 8'd0, 8'd255,
                                        16'h4000, 1'b0, '0));
      pending_beats.push_back(make_beat(OP_RANGE_WRITE, 8'd255, '0, 8'd0, 8'd255,
                                        16'h4000, 1'b1, '0));
      pending_beats.push_back(make_beat(OP_NONE, 8'd77, 24'hffffff, 8'hff, 8'hff,
                                        16'hffff, 1'b1, 32'hffffffff));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd100, '0, '0, '0, '0, 1'b0, 32'h0));
      queue_random(400);
      drain();

      write_csr(CSR_BLEND_ENABLE, 5'd1);
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd13, '0, '0, '0, '0, 1'b0, 32'h00ff0000));
      pending_beats.push_back(make_beat(OP_LOOKUP, 8'd1, '0, '0, '0, '0, 1'b0, 32'hffffffff));
      queue_random(400);
      drain();

      write_csr(CSR_RANGE_COUNT, 5'd31);
      queue_random(350);
      drain();

      write_csr(CSR_RANGE_COUNT, 5'd0);
      queue_random(100);
      drain();

      write_csr(CSR_BLEND_ENABLE, 5'd0);
      write_csr(CSR_RANGE_COUNT, 5'd5);
      no_gaps = 1'b1;
      queue_random(300);
      drain();

      $display("sent %0d beats, checked %0d lookups over blend off/on and 0 to 31 ranges",
               beats_sent, colors_checked);
      if (mismatches == 0 && expected_colors.size() == 0) begin
         $display("tb_palette_color_cycling_lookup_core: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_palette_color_cycling_lookup_core: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pccl_pkg.sv
rtl/palette_color_cycling_lookup_core.sv
rtl/pccl_checker.sv
tb/sv/tb_palette_color_cycling_lookup_core.sv
